[rtl/vfsd_pkg.sv]
// ----------------------------------------------------------------------------
// vfsd_pkg
// Shared types and constants of the voxel first-solid downsampler.
// ----------------------------------------------------------------------------
package vfsd_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_SHIFT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWNSAMPLE_STEP = 1'd1;

    localparam int MERGE_W     = 2;
    localparam int STEP_W      = 4;
    localparam int STEP_MAX    = 8;
    localparam int PHASE_W     = 3;
    localparam int COORD_OUT_W = 7;
    localparam int ID_W        = 16;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic last_cell;
    } t_req_ctl;

    typedef struct packed {
        logic [COORD_OUT_W-1:0] cell_x;
        logic [COORD_OUT_W-1:0] cell_y;
        logic [COORD_OUT_W-1:0] cell_z;
        logic [ID_W-1:0]        cell_block;
        logic                   cell_solid;
        logic                   last_cell;
    } t_cell;

endpackage

[rtl/vfsd_vox_if.sv]
// ----------------------------------------------------------------------------
// vfsd_vox_if
// Voxel input channel: one voxel word per handshake.
// ----------------------------------------------------------------------------
interface vfsd_vox_if;
    import vfsd_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] block_id;
    logic            chunk_present;
    logic            start_region;

    modport source (output valid, output block_id, output chunk_present,
                    output start_region, input ready);
    modport sink   (input valid, input block_id, input chunk_present,
                    input start_region, output ready);
endinterface

[rtl/vfsd_cell_if.sv]
// ----------------------------------------------------------------------------
// vfsd_cell_if
// Macro cell output channel: one cell word per handshake.
// ----------------------------------------------------------------------------
interface vfsd_cell_if;
    import vfsd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [COORD_OUT_W-1:0] cell_x;
    logic [COORD_OUT_W-1:0] cell_y;
    logic [COORD_OUT_W-1:0] cell_z;
    logic [ID_W-1:0]        cell_block;
    logic                   cell_solid;
    logic                   last_cell;

    modport source (output valid, output cell_x, output cell_y, output cell_z,
                    output cell_block, output cell_solid, output last_cell,
                    input ready);
    modport sink   (input valid, input cell_x, input cell_y, input cell_z,
                    input cell_block, input cell_solid, input last_cell,
                    output ready);
endinterface

[rtl/vfsd_pos.sv]
// ----------------------------------------------------------------------------
// vfsd_pos
// Voxel position counters and a three-stage divide-by-step pipeline that
// yields macro cell coordinates, cube phases and the cell store address.
// ----------------------------------------------------------------------------
module vfsd_pos #(
    parameter int CHUNK_SIDE      = 16,
    parameter int MAX_MACRO_WIDTH = 128,
    parameter int BLOCK_BITS      = 16
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_en,
    input  logic                                              i_fire,
    input  logic                                              i_start,
    input  logic [BLOCK_BITS-1:0]                             i_id,
    input  logic [vfsd_pkg::MERGE_W-1:0]                      i_merge_shift,
    input  logic [vfsd_pkg::STEP_W-1:0]                       i_step,
    output vfsd_pkg::t_req_ctl                                o_ctl,
    output logic [$clog2(MAX_MACRO_WIDTH*MAX_MACRO_WIDTH)-1:0] o_addr,
    output logic [BLOCK_BITS-1:0]                             o_id,
    output logic [vfsd_pkg::COORD_OUT_W-1:0]                  o_cx,
    output logic [vfsd_pkg::COORD_OUT_W-1:0]                  o_cy,
    output logic [vfsd_pkg::COORD_OUT_W-1:0]                  o_cz
);
    import vfsd_pkg::*;

    localparam int CW  = $clog2(CHUNK_SIDE * STEP_MAX);
    localparam int SW  = CW + 1;
    localparam int K   = SW + 3;
    localparam int RW  = K + 1;
    localparam int PW  = SW + RW;
    localparam int MCW = $clog2(MAX_MACRO_WIDTH + 1);
    localparam int MWW = (SW > MCW) ? SW : MCW;
    localparam int AW  = $clog2(MAX_MACRO_WIDTH * MAX_MACRO_WIDTH);

    localparam logic [RW-1:0] REC_1 = RW'(((1 << K) + 0) / 1);
    localparam logic [RW-1:0] REC_2 = RW'(((1 << K) + 1) / 2);
    localparam logic [RW-1:0] REC_3 = RW'(((1 << K) + 2) / 3);
    localparam logic [RW-1:0] REC_4 = RW'(((1 << K) + 3) / 4);
    localparam logic [RW-1:0] REC_5 = RW'(((1 << K) + 4) / 5);
    localparam logic [RW-1:0] REC_6 = RW'(((1 << K) + 5) / 6);
    localparam logic [RW-1:0] REC_7 = RW'(((1 << K) + 6) / 7);
    localparam logic [RW-1:0] REC_8 = RW'(((1 << K) + 7) / 8);

    logic [SW-1:0] side;
    logic [RW-1:0] recip;

    logic [CW-1:0] r_vx, r_vy, r_vz;
    logic [CW-1:0] n_vx, n_vy, n_vz;
    logic [CW-1:0] cur_x, cur_y, cur_z;
    logic          wrap_x, wrap_y, wrap_z;

    logic                  r_s1_v, r_s1_inr;
    logic [CW-1:0]         r_s1_x, r_s1_y, r_s1_z;
    logic [BLOCK_BITS-1:0] r_s1_id;

    logic                  r_s2_v, r_s2_inr;
    logic [CW-1:0]         r_s2_x, r_s2_y, r_s2_z;
    logic [PW-1:0]         r_s2_px, r_s2_py, r_s2_pz;
    logic [BLOCK_BITS-1:0] r_s2_id;

    logic [CW-1:0] qx, qy, qz;

    logic                  r_s3_v, r_s3_inr;
    logic [CW-1:0]         r_s3_qx, r_s3_qy, r_s3_qz;
    logic [PHASE_W-1:0]    r_s3_rx, r_s3_ry, r_s3_rz;
    logic [BLOCK_BITS-1:0] r_s3_id;

    logic [PW-1:0]      mw_prod;
    logic [MWW-1:0]     mw_raw;
    logic [MWW-1:0]     r_mw, n_mw;
    logic [PHASE_W-1:0] step_m1;
    logic               in_cells;

    assign side = SW'(CHUNK_SIDE) << i_merge_shift;

    always_comb begin
        unique case (i_step)
            4'd1:    recip = REC_1;
            4'd2:    recip = REC_2;
            4'd3:    recip = REC_3;
            4'd4:    recip = REC_4;
            4'd5:    recip = REC_5;
            4'd6:    recip = REC_6;
            4'd7:    recip = REC_7;
            4'd8:    recip = REC_8;
            default: recip = REC_1;
        endcase
    end

    // advance position, x fastest
    assign cur_x  = i_start ? '0 : r_vx;
    assign cur_y  = i_start ? '0 : r_vy;
    assign cur_z  = i_start ? '0 : r_vz;
    assign wrap_x = ({1'b0, cur_x} + SW'(1)) >= side;
    assign wrap_y = ({1'b0, cur_y} + SW'(1)) >= side;
    assign wrap_z = ({1'b0, cur_z} + SW'(1)) >= side;

    always_comb begin
        n_vx = wrap_x ? '0 : cur_x + CW'(1);
        n_vy = cur_y;
        n_vz = cur_z;
        if (wrap_x) begin
            n_vy = wrap_y ? '0 : cur_y + CW'(1);
            if (wrap_y) begin
                n_vz = wrap_z ? '0 : cur_z + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= '0;
            r_vy <= '0;
            r_vz <= '0;
        end else if (i_fire) begin
            r_vx <= n_vx;
            r_vy <= n_vy;
            r_vz <= n_vz;
        end
    end

    // macro width, clamped
    assign mw_prod = PW'(side) * PW'(recip);
    assign mw_raw  = MWW'(mw_prod >> K);
    assign n_mw    = (mw_raw > MWW'(MAX_MACRO_WIDTH)) ? MWW'(MAX_MACRO_WIDTH) : mw_raw;

    always_ff @(posedge i_clk) begin
        r_mw <= n_mw;
    end

    assign qx = CW'(r_s2_px >> K);
    assign qy = CW'(r_s2_py >> K);
    assign qz = CW'(r_s2_pz >> K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_fire;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_x   <= cur_x;
            r_s1_y   <= cur_y;
            r_s1_z   <= cur_z;
            r_s1_inr <= ({1'b0, cur_x} < side) && ({1'b0, cur_y} < side)
                        && ({1'b0, cur_z} < side);
            r_s1_id  <= i_id;

            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_z   <= r_s1_z;
            r_s2_px  <= PW'(r_s1_x) * PW'(recip);
            r_s2_py  <= PW'(r_s1_y) * PW'(recip);
            r_s2_pz  <= PW'(r_s1_z) * PW'(recip);
            r_s2_inr <= r_s1_inr;
            r_s2_id  <= r_s1_id;

            r_s3_qx  <= qx;
            r_s3_qy  <= qy;
            r_s3_qz  <= qz;
            r_s3_rx  <= PHASE_W'(r_s2_x - CW'(qx * CW'(i_step)));
            r_s3_ry  <= PHASE_W'(r_s2_y - CW'(qy * CW'(i_step)));
            r_s3_rz  <= PHASE_W'(r_s2_z - CW'(qz * CW'(i_step)));
            r_s3_inr <= r_s2_inr;
            r_s3_id  <= r_s2_id;
        end
    end

    assign step_m1  = PHASE_W'(i_step - STEP_W'(1));
    assign in_cells = (MWW'(r_s3_qx) < r_mw) && (MWW'(r_s3_qy) < r_mw)
                      && (MWW'(r_s3_qz) < r_mw);

    assign o_ctl.valid     = r_s3_v && r_s3_inr && in_cells;
    assign o_ctl.first     = (r_s3_rx == '0) && (r_s3_ry == '0) && (r_s3_rz == '0);
    assign o_ctl.last      = (r_s3_rx == step_m1) && (r_s3_ry == step_m1)
                             && (r_s3_rz == step_m1);
    assign o_ctl.last_cell = (MWW'(r_s3_qx) == r_mw - MWW'(1))
                             && (MWW'(r_s3_qy) == r_mw - MWW'(1))
                             && (MWW'(r_s3_qz) == r_mw - MWW'(1));

    assign o_addr = AW'(AW'(r_s3_qy) * AW'(MAX_MACRO_WIDTH) + AW'(r_s3_qx));
    assign o_id   = r_s3_id;
    assign o_cx   = COORD_OUT_W'(r_s3_qx);
    assign o_cy   = COORD_OUT_W'(r_s3_qy);
    assign o_cz   = COORD_OUT_W'(r_s3_qz);

endmodule

[rtl/vfsd_cell_mem.sv]
// ----------------------------------------------------------------------------
// vfsd_cell_mem
// Cell store with registered read, read-modify-write of the first non-air
// id per macro cell, and one-deep write forwarding.
// ----------------------------------------------------------------------------
module vfsd_cell_mem #(
    parameter int MAX_MACRO_WIDTH = 128,
    parameter int BLOCK_BITS      = 16
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_en,
    input  vfsd_pkg::t_req_ctl                                i_ctl,
    input  logic [$clog2(MAX_MACRO_WIDTH*MAX_MACRO_WIDTH)-1:0] i_addr,
    input  logic [BLOCK_BITS-1:0]                             i_id,
    input  logic [vfsd_pkg::COORD_OUT_W-1:0]                  i_cx,
    input  logic [vfsd_pkg::COORD_OUT_W-1:0]                  i_cy,
    input  logic [vfsd_pkg::COORD_OUT_W-1:0]                  i_cz,
    output logic                                              o_res_valid,
    output vfsd_pkg::t_cell                                   o_res
);
    import vfsd_pkg::*;

    localparam int DEPTH = MAX_MACRO_WIDTH * MAX_MACRO_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [BLOCK_BITS-1:0] mem [DEPTH];

    logic [BLOCK_BITS-1:0]  r_rd;
    t_req_ctl               r_s4_ctl;
    logic [AW-1:0]          r_s4_addr;
    logic [BLOCK_BITS-1:0]  r_s4_id;
    logic [COORD_OUT_W-1:0] r_s4_cx, r_s4_cy, r_s4_cz;

    logic                  r_fw_v;
    logic [AW-1:0]         r_fw_addr;
    logic [BLOCK_BITS-1:0] r_fw_data;

    logic [BLOCK_BITS-1:0] old_val;
    logic [BLOCK_BITS-1:0] new_val;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_s4_ctl.valid) begin
            mem[r_s4_addr] <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
            r_fw_v   <= 1'b0;
        end else if (i_en) begin
            r_s4_ctl <= i_ctl;
            r_fw_v   <= r_s4_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_addr <= i_addr;
            r_s4_id   <= i_id;
            r_s4_cx   <= i_cx;
            r_s4_cy   <= i_cy;
            r_s4_cz   <= i_cz;
            r_fw_addr <= r_s4_addr;
            r_fw_data <= new_val;
        end
    end

    // forward the write of the previous word
    assign old_val = (r_fw_v && (r_fw_addr == r_s4_addr)) ? r_fw_data : r_rd;
    assign new_val = (r_s4_ctl.first || (old_val == '0)) ? r_s4_id : old_val;

    assign o_res_valid      = r_s4_ctl.valid && r_s4_ctl.last;
    assign o_res.cell_x     = r_s4_cx;
    assign o_res.cell_y     = r_s4_cy;
    assign o_res.cell_z     = r_s4_cz;
    assign o_res.cell_block = ID_W'(new_val);
    assign o_res.cell_solid = (new_val != '0);
    assign o_res.last_cell  = r_s4_ctl.last_cell;

endmodule

[rtl/voxel_first_solid_downsampler.sv]
// ----------------------------------------------------------------------------
// voxel_first_solid_downsampler
// Throughput: one voxel per cycle while the skid word is empty, one cell
// store read-modify-write each, set by the single write port of the store
// with one-deep forwarding; a voxel runs through s1, s2, s3, s4 and r_out.
// Reset: clears position, pipeline valids, output words and configuration;
// the cell store is not cleared.
// ----------------------------------------------------------------------------
module voxel_first_solid_downsampler #(
    parameter int CHUNK_SIDE      = 16,
    parameter int MAX_MACRO_WIDTH = 128,
    parameter int BLOCK_BITS      = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vfsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vfsd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    vfsd_vox_if.sink                          i_vox,
    vfsd_cell_if.source                       o_cell
);
    import vfsd_pkg::*;

    localparam int AW = $clog2(MAX_MACRO_WIDTH * MAX_MACRO_WIDTH);

    logic [MERGE_W-1:0] r_merge_shift;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  eff_step;

    logic                   en;
    logic                   fire;
    logic [BLOCK_BITS-1:0]  vox_id;
    t_req_ctl               req_ctl;
    logic [AW-1:0]          req_addr;
    logic [BLOCK_BITS-1:0]  req_id;
    logic [COORD_OUT_W-1:0] req_cx, req_cy, req_cz;
    logic                   res_valid;
    t_cell                  res;
    logic                   new_v;
    logic                   out_free;

    logic  r_out_v, r_skid_v;
    t_cell r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_shift <= '0;
            r_step        <= STEP_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MERGE_SHIFT:     r_merge_shift <= i_cfg_data[MERGE_W-1:0];
                CFG_DOWNSAMPLE_STEP: r_step        <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_step == '0) begin
            eff_step = STEP_W'(1);
        end else if (r_step > STEP_W'(STEP_MAX)) begin
            eff_step = STEP_W'(STEP_MAX);
        end else begin
            eff_step = r_step;
        end
    end

    assign en          = !r_skid_v;
    assign i_vox.ready = en;
    assign fire        = i_vox.valid && en;
    assign vox_id      = i_vox.chunk_present ? i_vox.block_id[BLOCK_BITS-1:0] : '0;

    vfsd_pos #(
        .CHUNK_SIDE      (CHUNK_SIDE),
        .MAX_MACRO_WIDTH (MAX_MACRO_WIDTH),
        .BLOCK_BITS      (BLOCK_BITS)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_fire        (fire),
        .i_start       (i_vox.start_region),
        .i_id          (vox_id),
        .i_merge_shift (r_merge_shift),
        .i_step        (eff_step),
        .o_ctl         (req_ctl),
        .o_addr        (req_addr),
        .o_id          (req_id),
        .o_cx          (req_cx),
        .o_cy          (req_cy),
        .o_cz          (req_cz)
    );

    vfsd_cell_mem #(
        .MAX_MACRO_WIDTH (MAX_MACRO_WIDTH),
        .BLOCK_BITS      (BLOCK_BITS)
    ) u_cell_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_ctl       (req_ctl),
        .i_addr      (req_addr),
        .i_id        (req_id),
        .i_cx        (req_cx),
        .i_cy        (req_cy),
        .i_cz        (req_cz),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output word plus skid word
    assign new_v    = en && res_valid;
    assign out_free = !r_out_v || o_cell.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= new_v;
            end else begin
                r_out_v  <= new_v;
            end
        end else if (new_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out  <= res;
            end
        end else if (new_v) begin
            r_skid <= res;
        end
    end

    assign o_cell.valid      = r_out_v;
    assign o_cell.cell_x     = r_out.cell_x;
    assign o_cell.cell_y     = r_out.cell_y;
    assign o_cell.cell_z     = r_out.cell_z;
    assign o_cell.cell_block = r_out.cell_block;
    assign o_cell.cell_solid = r_out.cell_solid;
    assign o_cell.last_cell  = r_out.last_cell;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held without an output word");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_vox.ready)
        else $error("voxel accepted while skid word is full");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_cell.ready))
        else $error("skid word filled while output word was free");

endmodule
